FILE: sv/tbha_pkg.sv
// ----------------------------------------------------------------------------
// tbha_pkg
// Shared constants, codes and helpers for the tagged bitmap heap allocator.
// ----------------------------------------------------------------------------
package tbha_pkg;

   localparam int SIZE_W   = 22;
   localparam int UB_W     = 13;
   localparam int RSV_W    = 11;
   localparam int TAG_W    = 8;
   localparam int OUTCNT_W = 11;

   localparam logic [TAG_W-1:0] RSV_TAG = 8'd5;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] ST_BAD_FREE   = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic CSR_UNIT_BYTES = 1'b0;
   localparam logic CSR_RSV_UNITS  = 1'b1;

   localparam logic [UB_W-1:0]  UB_RESET  = 13'd16;
   localparam logic [RSV_W-1:0] RSV_RESET = 11'd64;

   // smallest nonzero tag above left that differs from right
   function automatic logic [TAG_W-1:0] pick_tag(input logic [TAG_W-1:0] left,
                                                 input logic [TAG_W-1:0] right);
      logic [TAG_W-1:0] t;
      t = left + 8'd1;
      if (t == 8'd0) t = 8'd1;
      if (t == right) begin
         t = t + 8'd1;
         if (t == 8'd0) t = 8'd1;
      end
      return t;
   endfunction

endpackage

FILE: sv/tbha_div.sv
// ----------------------------------------------------------------------------
// tbha_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbha_div
   import tbha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SIZE_W-1:0] dividend,
   input  logic [UB_W-1:0]   divisor,
   output logic              done,
   output logic [SIZE_W-1:0] quotient,
   output logic [UB_W-1:0]   remainder
);

   logic [UB_W-1:0]   rem_ff, rem_in;
   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [UB_W-1:0]   dvs_ff, dvs_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [UB_W:0]     trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[SIZE_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 5'(SIZE_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = UB_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[SIZE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[UB_W-1:0];
            quo_in = {quo_ff[SIZE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/tbha_tag_ram.sv
// ----------------------------------------------------------------------------
// tbha_tag_ram
// Tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tbha_tag_ram
   import tbha_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [TAG_W-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [TAG_W-1:0] rd_data
);

   logic [TAG_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/tagged_bitmap_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// tagged_bitmap_heap_allocator_core
// Next-fit heap allocator over a tag store, one tag per allocation unit.
//
//  channel | dir | fields (tdata / tuser, low bit first)
//  req     | in  | tdata: size_bytes, offset_bytes ; tuser: func
//  rsp     | out | tdata: status, result_offset, run_units, run_tag, used_units
//  csr     | in  | index 0 unit_bytes, index 1 reserved_units
//
// Allocate runs the divider, a usage count over all units, a next-fit scan
// of up to two passes and a run write; free runs the divider, the usage
// count and a walk along the run. The tag store has a single read port.
// After reset a clearing pass writes every unit before the first word is
// taken. A new request word is taken while a result word waits on rsp.
// ----------------------------------------------------------------------------
module tagged_bitmap_heap_allocator_core
   import tbha_pkg::*;
#(
   parameter int UNITS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [47:0]       req_tdata,  // size_bytes, offset_bytes
   input  logic              req_tuser,  // func
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [55:0]       rsp_tdata,  // status, result_offset, run_units, run_tag, used_units
   input  logic              csr_we,
   input  logic              csr_addr,
   input  logic [UB_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(UNITS);
   localparam int CW = $clog2(UNITS + 1);
   localparam int PW = AW + UB_W;
   localparam logic [AW-1:0] LAST    = AW'(UNITS - 1);
   localparam logic [CW-1:0] UNITS_C = CW'(UNITS);

   typedef enum logic [12:0] {
      S_CLEAR = 13'b0000000000001,
      S_IDLE  = 13'b0000000000010,
      S_DIV   = 13'b0000000000100,
      S_CNT   = 13'b0000000001000,
      S_CHK   = 13'b0000000010000,
      S_SCAN  = 13'b0000000100000,
      S_NL    = 13'b0000001000000,
      S_NR    = 13'b0000010000000,
      S_NT    = 13'b0000100000000,
      S_WR    = 13'b0001000000000,
      S_FREE  = 13'b0010000000000,
      S_MUL   = 13'b0100000000000,
      S_OUT   = 13'b1000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic              func_ff, func_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [UB_W-1:0]   ub_ff, ub_in;
   logic [RSV_W-1:0]  rsv_ff, rsv_in;
   logic [AW-1:0]     cursor_ff, cursor_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [CW-1:0]     need_ff, need_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [AW-1:0]     start_ff, start_in;
   logic [AW-1:0]     sstart_ff, sstart_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              inrun_ff, inrun_in;
   logic              issue_ff, issue_in;
   logic              rv_ff;
   logic [AW-1:0]     scan_ff, scan_in;
   logic              pass_ff, pass_in;
   logic              pass_q_ff;
   logic [AW-1:0]     addr_q_ff;
   logic              first_ff, first_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [TAG_W-1:0]  left_ff, left_in;
   logic [1:0]        status_ff, status_in;
   logic [SIZE_W-1:0] prod_ff, prod_in;
   logic              rsp_v_ff, rsp_v_in;
   logic [1:0]        o_status_ff, o_status_in;
   logic [SIZE_W-1:0] o_off_ff, o_off_in;
   logic [OUTCNT_W-1:0] o_units_ff, o_units_in;
   logic [TAG_W-1:0]  o_tag_ff, o_tag_in;
   logic [OUTCNT_W-1:0] o_used_ff, o_used_in;

   logic              div_start, div_done;
   logic [SIZE_W-1:0] div_quo;
   logic [UB_W-1:0]   div_rem;
   logic [UB_W-1:0]   ub_eff;
   logic [CW-1:0]     rsv_eff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, rd_addr;
   logic [TAG_W-1:0]  mem_wdata, mem_q, tag_eff;
   logic [SIZE_W:0]   need_w;
   logic [CW:0]       right_pos;
   logic [CW-1:0]     len_nx, cnt_nx;
   logic              unit_free, start_ok, a_fail;
   logic [PW-1:0]     prod_w;

   assign ub_eff  = (ub_ff == '0) ? UB_W'(1) : ub_ff;
   assign rsv_eff = (32'(rsv_ff) > UNITS) ? UNITS_C : CW'(rsv_ff);
   assign tag_eff = (CW'(addr_q_ff) < rsv_eff) ? RSV_TAG : mem_q;
   assign need_w  = {1'b0, div_quo} + (SIZE_W+1)'(div_rem != '0);
   assign right_pos = (CW+1)'(base_ff) + (CW+1)'(need_ff);
   assign prod_w  = PW'(base_ff) * PW'(ub_eff);

   tbha_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  ((req_tuser == FUNC_FREE) ? req_tdata[43:22] : req_tdata[21:0]),
      .divisor   (ub_eff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   tbha_tag_ram #(.DEPTH(UNITS), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   always_comb begin
      case (state_ff)
         S_NL:    rd_addr = base_ff - AW'(1);
         S_NR:    rd_addr = AW'(right_pos);
         default: rd_addr = scan_ff;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      size_in   = size_ff;
      ub_in     = ub_ff;
      rsv_in    = rsv_ff;
      cursor_in = cursor_ff;
      used_in   = used_ff;
      need_in   = need_ff;
      base_in   = base_ff;
      start_in  = start_ff;
      sstart_in = sstart_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      inrun_in  = inrun_ff;
      issue_in  = issue_ff;
      scan_in   = scan_ff;
      pass_in   = pass_ff;
      first_in  = first_ff;
      tag_in    = tag_ff;
      left_in   = left_ff;
      status_in = status_ff;
      prod_in   = prod_ff;
      rsp_v_in  = rsp_v_ff && !rsp_tready;
      o_status_in = o_status_ff;
      o_off_in    = o_off_ff;
      o_units_in  = o_units_ff;
      o_tag_in    = o_tag_ff;
      o_used_in   = o_used_ff;
      div_start = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_q_ff;
      mem_wdata = '0;
      req_tready = 1'b0;
      unit_free = (tag_eff == '0);
      start_ok  = !pass_q_ff || (addr_q_ff < sstart_ff);
      len_nx    = inrun_ff ? len_ff + CW'(1) : CW'(1);
      cnt_nx    = cnt_ff;
      a_fail    = 1'b0;

      if (csr_we) begin
         case (csr_addr)
            CSR_UNIT_BYTES: ub_in  = csr_wdata;
            CSR_RSV_UNITS:  rsv_in = csr_wdata[RSV_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            scan_in   = scan_ff + AW'(1);
            if (scan_ff == LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in   = req_tuser;
               size_in   = req_tdata[21:0];
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               scan_in  = '0;
               issue_in = 1'b1;
               used_in  = '0;
               state_in = S_CNT;
            end
         end
         S_CNT: begin
            if (issue_ff) begin
               scan_in = scan_ff + AW'(1);
               if (scan_ff == LAST) issue_in = 1'b0;
            end
            if (rv_ff) begin
               used_in = used_ff + CW'(tag_eff != '0);
               if (addr_q_ff == LAST) state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (func_ff == FUNC_ALLOC) begin
               if (size_ff == '0 || need_w > (SIZE_W+1)'(UNITS_C - used_ff)) begin
                  a_fail = 1'b1;
               end else begin
                  need_in   = CW'(need_w);
                  scan_in   = (cursor_ff == LAST) ? '0 : cursor_ff + AW'(1);
                  sstart_in = (cursor_ff == LAST) ? '0 : cursor_ff + AW'(1);
                  pass_in   = 1'b0;
                  inrun_in  = 1'b0;
                  issue_in  = 1'b1;
                  state_in  = S_SCAN;
               end
            end else begin
               if (32'(div_quo) >= UNITS || 32'(div_quo) < 32'(rsv_eff)) begin
                  status_in = ST_BAD_FREE;
                  base_in   = '0;
                  cnt_in    = '0;
                  tag_in    = '0;
                  state_in  = S_MUL;
               end else begin
                  base_in  = AW'(div_quo);
                  scan_in  = AW'(div_quo);
                  first_in = 1'b1;
                  cnt_in   = '0;
                  issue_in = 1'b1;
                  state_in = S_FREE;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               scan_in = (scan_ff == LAST) ? '0 : scan_ff + AW'(1);
               if (scan_ff == LAST) begin
                  if (pass_ff) issue_in = 1'b0;
                  else pass_in = 1'b1;
               end
            end
            if (rv_ff) begin
               if (unit_free && (inrun_ff || start_ok)) begin
                  inrun_in = 1'b1;
                  len_in   = len_nx;
                  if (!inrun_ff) start_in = addr_q_ff;
                  if (len_nx == need_ff) begin
                     base_in  = inrun_ff ? start_ff : addr_q_ff;
                     issue_in = 1'b0;
                     state_in = S_NL;
                  end else if (addr_q_ff == LAST) begin
                     inrun_in = 1'b0;
                     if (pass_q_ff) a_fail = 1'b1;
                  end
               end else if (unit_free) begin
                  a_fail = 1'b1;
               end else begin
                  inrun_in = 1'b0;
                  if (pass_q_ff && addr_q_ff >= sstart_ff) a_fail = 1'b1;
               end
            end
         end
         S_NL: begin
            state_in = S_NR;
         end
         S_NR: begin
            left_in  = (base_ff == '0) ? '0 : tag_eff;
            state_in = S_NT;
         end
         S_NT: begin
            tag_in   = pick_tag(left_ff,
                                (right_pos >= (CW+1)'(UNITS)) ? '0 : tag_eff);
            scan_in  = base_ff;
            cnt_in   = '0;
            state_in = S_WR;
         end
         S_WR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = tag_ff;
            scan_in   = scan_ff + AW'(1);
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == need_ff - CW'(1)) begin
               cursor_in = scan_ff;
               used_in   = used_ff + need_ff;
               cnt_in    = need_ff;
               status_in = ST_OK;
               state_in  = S_MUL;
            end
         end
         S_FREE: begin
            if (issue_ff) begin
               scan_in = scan_ff + AW'(1);
               if (scan_ff == LAST) issue_in = 1'b0;
            end
            if (rv_ff) begin
               if (first_ff && mem_q == '0) begin
                  status_in = ST_BAD_FREE;
                  base_in   = '0;
                  tag_in    = '0;
                  issue_in  = 1'b0;
                  state_in  = S_MUL;
               end else begin
                  first_in = 1'b0;
                  if (first_ff || mem_q == tag_ff) begin
                     // clear this unit and keep walking
                     mem_we = 1'b1;
                     cnt_nx = cnt_ff + CW'(1);
                     cnt_in = cnt_nx;
                     if (first_ff) tag_in = mem_q;
                  end
                  if ((!first_ff && mem_q != tag_ff) || addr_q_ff == LAST) begin
                     used_in   = used_ff - cnt_nx;
                     status_in = ST_OK;
                     issue_in  = 1'b0;
                     state_in  = S_MUL;
                  end
               end
            end
         end
         S_MUL: begin
            prod_in  = SIZE_W'(prod_w);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in    = 1'b1;
               o_status_in = status_ff;
               o_off_in    = prod_ff;
               o_units_in  = OUTCNT_W'(cnt_ff);
               o_tag_in    = tag_ff;
               o_used_in   = OUTCNT_W'(used_ff);
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (a_fail) begin
         status_in = ST_ALLOC_FAIL;
         base_in   = '0;
         cnt_in    = '0;
         tag_in    = '0;
         issue_in  = 1'b0;
         state_in  = S_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         ub_ff     <= UB_RESET;
         rsv_ff    <= RSV_RESET;
         cursor_ff <= LAST;
         scan_ff   <= '0;
         issue_ff  <= 1'b0;
         rv_ff     <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ub_ff     <= ub_in;
         rsv_ff    <= rsv_in;
         cursor_ff <= cursor_in;
         scan_ff   <= scan_in;
         issue_ff  <= issue_in;
         rv_ff     <= issue_ff;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      size_ff     <= size_in;
      used_ff     <= used_in;
      need_ff     <= need_in;
      base_ff     <= base_in;
      start_ff    <= start_in;
      sstart_ff   <= sstart_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      inrun_ff    <= inrun_in;
      pass_ff     <= pass_in;
      pass_q_ff   <= pass_ff;
      addr_q_ff   <= rd_addr;
      first_ff    <= first_in;
      tag_ff      <= tag_in;
      left_ff     <= left_in;
      status_ff   <= status_in;
      prod_ff     <= prod_in;
      o_status_ff <= o_status_in;
      o_off_ff    <= o_off_in;
      o_units_ff  <= o_units_in;
      o_tag_ff    <= o_tag_in;
      o_used_ff   <= o_used_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {2'b00, o_used_ff, o_tag_ff, o_units_ff, o_off_ff, o_status_ff};

endmodule

FILE: tb/tagged_bitmap_heap_allocator_core_test.sv
// ----------------------------------------------------------------------------
// tagged_bitmap_heap_allocator_core_test
// Self-checking bench for the next-fit tagged heap allocator. A queue of
// request words feeds a clocked driver. A clocked monitor checks each response
// word against a shadow tag store that the bench keeps itself. Gaps on both
// sides are random. Unit size and reserve change between phases.
// ----------------------------------------------------------------------------
module tagged_bitmap_heap_allocator_core_test;
   import tbha_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUNITS = 1024;
   localparam longint CYCLE_LIMIT = 8000000;

   typedef struct packed {
      logic              func;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] offs;
   } heap_req_type;

   // low bit first on rsp_tdata: status, offset, run units, tag, used
   typedef struct packed {
      logic [OUTCNT_W-1:0] used;
      logic [TAG_W-1:0]    rtag;
      logic [OUTCNT_W-1:0] runits;
      logic [SIZE_W-1:0]   roff;
      logic [1:0]          status;
   } heap_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [UB_W-1:0] csr_wdata = '0;

   tagged_bitmap_heap_allocator_core #(.UNITS(NUNITS)) dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow allocator state
   logic [TAG_W-1:0] shadow_tags [NUNITS];
   int unsigned      cursor;
   int unsigned      unit_sz;
   int unsigned      rsv_cnt;
   int unsigned      live_units[$];

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int        errors = 0;
   longint    cycles = 0;
   bit        long_hold_req = 1'b0;

   function automatic int unsigned eff_ub();
      return (unit_sz == 0) ? 1 : unit_sz;
   endfunction

   function automatic int unsigned eff_rsv();
      return (rsv_cnt > NUNITS) ? NUNITS : rsv_cnt;
   endfunction

   function automatic int unsigned tag_of(int unsigned u);
      if (u >= NUNITS) return 0;
      if (u < eff_rsv()) return RSV_TAG;
      return shadow_tags[u];
   endfunction

   function automatic int unsigned count_used();
      int unsigned n;
      n = 0;
      for (int unsigned u = 0; u < NUNITS; u++)
         if (tag_of(u) != 0) n++;
      return n;
   endfunction

   function automatic int unsigned next_tag(int unsigned left, int unsigned right);
      int unsigned t;
      t = (left + 1) & 8'hFF;
      while (t == 0 || t == right) t = (t + 1) & 8'hFF;
      return t;
   endfunction

   // apply one request to the shadow store and queue its response
   task automatic heap_predict(input heap_req_type r);
      heap_rsp_type e;
      int unsigned ub, need, pos, seen, run, t, u, i;
      bit          done;
      ub = eff_ub();
      e = '0;
      done = 1'b0;
      if (r.func == FUNC_ALLOC) begin
         need = r.size / ub + ((r.size % ub) != 0);
         if (r.size != 0 && need <= NUNITS - count_used()) begin
            pos = cursor + 1;
            seen = 0;
            if (pos >= NUNITS) pos = 0;
            while (seen < NUNITS && !done) begin
               if (tag_of(pos) != 0) begin
                  pos++;
                  seen++;
               end else begin
                  run = 0;
                  while (run < need && pos + run < NUNITS && tag_of(pos + run) == 0) run++;
                  if (run == need) begin
                     t = next_tag(pos > 0 ? tag_of(pos - 1) : 0, tag_of(pos + need));
                     for (int unsigned k = 0; k < need; k++)
                        shadow_tags[pos + k] = TAG_W'(t);
                     cursor = pos + need - 1;
                     e.roff = SIZE_W'(pos * ub);
                     e.runits = OUTCNT_W'(need);
                     e.rtag = TAG_W'(t);
                     live_units.push_back(pos);
                     done = 1'b1;
                  end else begin
                     pos += run;
                     seen += run;
                  end
               end
               if (pos >= NUNITS) pos = 0;
            end
         end
         if (!done) e.status = ST_ALLOC_FAIL;
      end else begin
         u = r.offs / ub;
         if (u >= NUNITS || u < eff_rsv() || shadow_tags[u] == 0) begin
            e.status = ST_BAD_FREE;
         end else begin
            t = shadow_tags[u];
            i = u;
            while (i < NUNITS && shadow_tags[i] == t) begin
               shadow_tags[i] = '0;
               i++;
            end
            e.runits = OUTCNT_W'(i - u);
            e.roff = SIZE_W'(u * ub);
            e.rtag = TAG_W'(t);
         end
      end
      e.used = OUTCNT_W'(count_used());
      expected_rsps.push_back(e);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // request driver
   int unsigned  req_gap = 0;
   heap_req_type cur_req;
   always @(posedge clock) begin
      bit fire;
      fire = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (fire) begin
            heap_predict(cur_req);
            req_gap = pick_gap();
         end
         if (!req_tvalid || fire) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0, cur_req.offs, cur_req.size};
               req_tuser <= cur_req.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   int unsigned hold_left = 0;
   always @(posedge clock) begin
      heap_rsp_type got, e;
      got = rsp_tdata[53:0];
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (got.status !== e.status) begin
                  $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                  errors++;
               end
               if (got.roff !== e.roff) begin
                  $display("%0t: offset exp %0d got %0d", $time, e.roff, got.roff);
                  errors++;
               end
               if (got.runits !== e.runits) begin
                  $display("%0t: run units exp %0d got %0d", $time, e.runits, got.runits);
                  errors++;
               end
               if (got.rtag !== e.rtag) begin
                  $display("%0t: tag exp %0d got %0d", $time, e.rtag, got.rtag);
                  errors++;
               end
               if (got.used !== e.used) begin
                  $display("%0t: used exp %0d got %0d", $time, e.used, got.used);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 15000;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 4) begin
            hold_left = $urandom_range(10, 60);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 75);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send(input logic func, input int unsigned size, input int unsigned offs);
      heap_req_type r;
      r.func = func;
      r.size = size[SIZE_W-1:0];
      r.offs = offs[SIZE_W-1:0];
      pending_reqs.push_back(r);
      while (pending_reqs.size() > 1) @(posedge clock);
   endtask

   task automatic wait_idle();
      forever begin
         @(posedge clock);
         #1;
         if (pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0) break;
      end
   endtask

   task automatic csr_write(input logic addr, input int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= val[UB_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_UNIT_BYTES) unit_sz = val & 13'h1FFF;
      else rsv_cnt = val & 11'h7FF;
   endtask

   task automatic set_config(input int unsigned ub, input int unsigned rsv);
      wait_idle();
      csr_write(CSR_UNIT_BYTES, ub);
      csr_write(CSR_RSV_UNITS, rsv);
   endtask

   task automatic random_items(input int n);
      int unsigned r, ub, need, u, idx;
      ub = eff_ub();
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            need = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 400)
                                                 : $urandom_range(1, 8);
            send(FUNC_ALLOC, (need - 1) * ub + $urandom_range(1, ub), 0);
         end else if (r < 88 && live_units.size() > 0) begin
            idx = $urandom_range(0, live_units.size() - 1);
            u = live_units[idx];
            live_units.delete(idx);
            // sometimes free from the middle of the run
            if ($urandom_range(0, 4) == 0) u += $urandom_range(1, 3);
            send(FUNC_FREE, $urandom, u * ub + $urandom_range(0, ub - 1));
         end else begin
            send(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0 ? 0 : $urandom,
                 $urandom);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUNITS; i++) shadow_tags[i] = '0;
      cursor = NUNITS - 1;
      unit_sz = UB_RESET;
      rsv_cnt = RSV_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: directed corners
      send(FUNC_ALLOC, 0, 0);
      send(FUNC_ALLOC, 1, 0);
      send(FUNC_ALLOC, 16, 0);
      send(FUNC_ALLOC, 17, 0);
      send(FUNC_ALLOC, 22'h3FFFFF, 0);
      send(FUNC_FREE, 0, 0);
      send(FUNC_FREE, 22'h3FFFFF, 22'h3FFFFF);
      send(FUNC_FREE, 0, 500 * 16);
      send(FUNC_FREE, 0, 2 * 16 + 5);
      send(FUNC_FREE, 0, 3 * 16);
      send(FUNC_FREE, 0, 0 * 16);
      send(FUNC_ALLOC, 955 * 16, 0);
      send(FUNC_ALLOC, 16, 0);
      send(FUNC_FREE, 0, 100 * 16);
      random_items(90);

      set_config(1, 0);
      random_items(55);

      // full reserve hides stored entries
      set_config(4096, 1024);
      send(FUNC_ALLOC, 1, 0);
      send(FUNC_FREE, 0, 4096 * 200);
      send(FUNC_FREE, 0, 22'h3FFFFF);
      random_items(6);

      set_config(0, 2047);
      send(FUNC_ALLOC, 1, 0);
      send(FUNC_FREE, 0, 1000);
      random_items(4);

      set_config(3, 10);
      random_items(20);
      long_hold_req = 1'b1;
      random_items(50);

      set_config(8191, 0);
      random_items(45);

      wait_idle();
      repeat (3500) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
